FILE: design/slfr_pkg.sv
package slfr_pkg;

  // Receive phase of the frame parser.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_DATA  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  // Reset value of the start byte register (ASCII STX).
  localparam logic [7:0] START_BYTE_RESET = 8'h02;

  // One result item as it travels from the parser to the output register.
  typedef struct packed {
    logic       too_long;
    logic       frame_good;
    logic       end_of_frame;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
  } result_t;

endpackage

FILE: design/stx_length_bcc_frame_receiver_unit.sv
// Frame receiver for start / length / payload / XOR-check framing. Received
// bytes enter on the s_axis stream, one per transaction; a frame is the start
// byte, a length byte L, L payload bytes and a check byte equal to the XOR of
// the start byte, L and the payload. Bytes seen while idle that are not the
// start byte are dropped. Each payload byte within the first MAX_PAYLOAD is
// sent on m_axis with its index; after the check byte one transaction with
// tlast high carries the status in tuser. The block takes one byte per clock
// cycle while m_axis does not hold back its results; a byte passes through an
// input register and then a result register before its result is valid on
// m_axis. The start byte is set through the cfg port (reset value 0x02) and
// should be written while idle.
module stx_length_bcc_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,      // [7:0] start_byte
  // Received bytes.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] data_byte, [15:8] byte_index
  output logic        m_axis_tlast,  // end_of_frame
  output logic [1:0]  m_axis_tuser   // [0] frame_good, [1] too_long
);
  import slfr_pkg::*;

  logic       start_byte;
  logic [7:0] start_value;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;
  logic       can_take;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // Start byte register; writes are always taken.
  assign cfg_ready  = 1'b1;
  assign start_byte = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= START_BYTE_RESET;
    end else if (start_byte) begin
      start_value <= cfg_data;
    end
  end

  // A held byte is parsed when the result register can take its result.
  assign advance = held_valid && can_take;

  slfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  slfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .rx_byte    (held_byte),
    .start_byte (start_value),
    .res_valid  (res_valid),
    .res        (res)
  );

  slfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Pack the result onto the stream fields.
  assign m_axis_tdata = {out_res.byte_index, out_res.data_byte};
  assign m_axis_tlast = out_res.end_of_frame;
  assign m_axis_tuser = {out_res.too_long, out_res.frame_good};

endmodule

FILE: design/slfr_in_stage.sv
module slfr_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // The register takes a new byte when it is empty or its byte moves on.
  assign in_ready = !held_valid || advance;

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

endmodule

FILE: design/slfr_parser.sv
module slfr_parser #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        start_byte,
  output logic              res_valid,
  output slfr_pkg::result_t res
);
  import slfr_pkg::*;

  localparam logic [7:0] MaxPayload = 8'(MAX_PAYLOAD);

  phase_t     phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_check, running_check_next;
  logic [7:0] next_index, next_index_next;
  logic       overlength, overlength_next;
  logic [7:0] left_dec;

  // Remaining count after a payload byte, held at zero.
  assign left_dec = (bytes_left != 8'd0) ? bytes_left - 8'd1 : 8'd0;

  // Next-state logic.
  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    running_check_next = running_check;
    next_index_next    = next_index;
    overlength_next    = overlength;
    if (step) begin
      case (phase)
        PH_IDLE: begin
          if (rx_byte == start_byte) begin
            running_check_next = start_byte;
            phase_next         = PH_LEN;
          end
        end
        PH_LEN: begin
          running_check_next = running_check ^ rx_byte;
          bytes_left_next    = rx_byte;
          next_index_next    = 8'd0;
          overlength_next    = rx_byte > MaxPayload;
          phase_next         = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          running_check_next = running_check ^ rx_byte;
          if (next_index != 8'hFF) begin
            next_index_next = next_index + 8'd1;
          end
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_next         = PH_IDLE;
          bytes_left_next    = 8'd0;
          running_check_next = 8'd0;
          next_index_next    = 8'd0;
          overlength_next    = 1'b0;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Result logic: a payload byte that fits the buffer, or the frame status.
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (phase)
      PH_DATA: begin
        if (next_index < MaxPayload) begin
          res_valid      = step;
          res.data_byte  = rx_byte;
          res.byte_index = next_index;
        end
      end
      PH_CHECK: begin
        res_valid        = step;
        res.end_of_frame = 1'b1;
        res.frame_good   = (running_check == rx_byte) && !overlength;
        res.too_long     = overlength;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bytes_left    <= 8'd0;
      running_check <= 8'd0;
      next_index    <= 8'd0;
      overlength    <= 1'b0;
    end else begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      running_check <= running_check_next;
      next_index    <= next_index_next;
      overlength    <= overlength_next;
    end
  end

endmodule

FILE: design/slfr_out_stage.sv
module slfr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              res_valid,
  input  slfr_pkg::result_t res,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output slfr_pkg::result_t out_res
);
  import slfr_pkg::*;

  // The register is free when empty or when its transaction completes now.
  assign can_take = !out_valid || out_ready;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload of the result register.
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_res <= res;
    end
  end

endmodule
